// ----- sv/cmp_pkg.sv -----
// Shared types and constants for the CoAP message parser.
package cmp_pkg;

    // Default and derived sizes.
    localparam int CMP_MAX_DATAGRAM = 256;
    localparam int CFG_W            = 5;
    localparam int TDATA_W          = 80;
    localparam int FIELDS_W         = 73;
    localparam int TUSER_W          = 3;

    // Protocol constants.
    localparam logic [CFG_W-1:0] OPT_LIMIT_RESET = 5'd10;
    localparam logic [1:0]       COAP_VERSION    = 2'b01;
    localparam logic [3:0]       TKL_MAX         = 4'd8;
    localparam logic [7:0]       PAYLOAD_MARKER  = 8'hFF;
    localparam logic [3:0]       NIB_EXT1        = 4'd13;
    localparam logic [3:0]       NIB_EXT2        = 4'd14;
    localparam logic [3:0]       NIB_RESERVED    = 4'hF;
    localparam logic [15:0]      EXT1_BASE       = 16'd13;
    localparam logic [15:0]      EXT2_BASE       = 16'd269;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_H0      = 4'd0,
        PH_H1      = 4'd1,
        PH_H2      = 4'd2,
        PH_H3      = 4'd3,
        PH_TOKEN   = 4'd4,
        PH_OPT     = 4'd5,
        PH_DX1     = 4'd6,
        PH_DX2     = 4'd7,
        PH_LX1     = 4'd8,
        PH_LX2     = 4'd9,
        PH_VALUE   = 4'd10,
        PH_PAYLOAD = 4'd11,
        PH_SKIP    = 4'd12,
        PH_DISCARD = 4'd13
    } cmp_phase_t;

    // Result kinds.
    typedef enum logic [2:0] {
        EV_HEADER   = 3'd0,
        EV_TOKEN    = 3'd1,
        EV_OPTSTART = 3'd2,
        EV_OPTBYTE  = 3'd3,
        EV_PAYLOAD  = 3'd4,
        EV_END      = 3'd5,
        EV_REJECT   = 3'd6
    } cmp_event_kind_t;

    // Reject reasons.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_VERSION   = 3'd2,
        ERR_TKL       = 3'd3,
        ERR_NIBBLE15  = 3'd4,
        ERR_TRUNCATED = 3'd5
    } cmp_error_t;

    // One result item.
    typedef struct packed {
        cmp_event_kind_t event_kind;
        logic [1:0]      msg_type;
        logic [3:0]      token_length;
        logic [7:0]      msg_code;
        logic [15:0]     message_id;
        logic [15:0]     option_number;
        logic [15:0]     option_length;
        logic [7:0]      data_out;
        cmp_error_t      error_code;
        logic            end_of_message;
    } cmp_event_t;

endpackage

// ----- sv/cmp_core.sv -----
// Per-byte parser: message state registers and the single-pass byte decode.
module cmp_core
    import cmp_pkg::*;
#(
    parameter int MAX_DATAGRAM = CMP_MAX_DATAGRAM
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic [CFG_W-1:0] option_limit,
    output logic             ev_valid,
    output cmp_event_t       ev
);

    localparam int PW = $clog2(MAX_DATAGRAM);

    cmp_phase_t  phase_reg, phase_next, phase_sw;
    logic [PW-1:0] pos_reg, pos_next;
    logic [23:0] hold_reg, hold_next;
    logic [3:0]  token_left_reg, token_left_next;
    logic [15:0] running_reg, running_next;
    logic [3:0]  delta_nib_reg, delta_nib_next;
    logic [3:0]  length_nib_reg, length_nib_next;
    logic [7:0]  ext_reg, ext_next;
    logic [15:0] value_left_reg, value_left_next;
    logic [4:0]  opts_seen_reg, opts_seen_next;
    logic [1:0]  hdr_type_reg, hdr_type_next;
    logic [3:0]  hdr_tkl_reg, hdr_tkl_next;
    logic [7:0]  hdr_code_reg, hdr_code_next;
    logic [15:0] hdr_mid_reg, hdr_mid_next;
    logic [15:0] opt_delta_reg, opt_delta_next;
    logic [15:0] opt_length_reg, opt_length_next;

    logic            active;
    logic            fin;
    logic            sw_has;
    cmp_event_kind_t sw_kind;
    cmp_error_t      sw_err;
    logic [15:0]     sw_num;
    logic [15:0]     sw_len;
    logic [7:0]      sw_data;
    logic            sw_reject;

    assign active    = (phase_reg != PH_DISCARD);
    assign fin       = in_last || (pos_reg == PW'(MAX_DATAGRAM - 1));
    assign sw_reject = sw_has && (sw_kind == EV_REJECT);

    // Next state: decode one byte according to the current phase.
    always_comb
    begin
        logic [15:0] delta_val;
        logic [15:0] length_val;
        logic [15:0] run_sum;
        logic [3:0]  len_nib;
        logic        do_len_stage;
        logic        do_finish;

        delta_val       = 16'd0;
        length_val      = 16'd0;
        run_sum         = 16'd0;
        len_nib         = length_nib_reg;
        do_len_stage    = 1'b0;
        do_finish       = 1'b0;

        phase_sw        = phase_reg;
        hold_next       = hold_reg;
        token_left_next = token_left_reg;
        running_next    = running_reg;
        delta_nib_next  = delta_nib_reg;
        length_nib_next = length_nib_reg;
        ext_next        = ext_reg;
        value_left_next = value_left_reg;
        opts_seen_next  = opts_seen_reg;
        hdr_type_next   = hdr_type_reg;
        hdr_tkl_next    = hdr_tkl_reg;
        hdr_code_next   = hdr_code_reg;
        hdr_mid_next    = hdr_mid_reg;
        opt_delta_next  = opt_delta_reg;
        opt_length_next = opt_length_reg;

        sw_has  = 1'b0;
        sw_kind = EV_HEADER;
        sw_err  = ERR_NONE;
        sw_num  = 16'd0;
        sw_len  = 16'd0;
        sw_data = 8'd0;

        case (phase_reg)
            PH_H0:
            begin
                hold_next = {in_byte, 16'd0};
                phase_sw  = PH_H1;
            end
            PH_H1:
            begin
                hold_next[15:8] = in_byte;
                phase_sw        = PH_H2;
            end
            PH_H2:
            begin
                hold_next[7:0] = in_byte;
                phase_sw       = PH_H3;
            end
            PH_H3:
            begin
                hdr_type_next = hold_reg[21:20];
                hdr_tkl_next  = hold_reg[19:16];
                hdr_code_next = hold_reg[15:8];
                hdr_mid_next  = {hold_reg[7:0], in_byte};
                if (hold_reg[23:22] != COAP_VERSION)
                begin
                    sw_has   = 1'b1;
                    sw_kind  = EV_REJECT;
                    sw_err   = ERR_VERSION;
                    phase_sw = PH_DISCARD;
                end
                else if (hold_reg[19:16] > TKL_MAX)
                begin
                    sw_has   = 1'b1;
                    sw_kind  = EV_REJECT;
                    sw_err   = ERR_TKL;
                    phase_sw = PH_DISCARD;
                end
                else
                begin
                    sw_has          = 1'b1;
                    sw_kind         = EV_HEADER;
                    token_left_next = hold_reg[19:16];
                    phase_sw        = (hold_reg[19:16] != 4'd0) ? PH_TOKEN : PH_OPT;
                end
            end
            PH_TOKEN:
            begin
                sw_has          = 1'b1;
                sw_kind         = EV_TOKEN;
                sw_data         = in_byte;
                token_left_next = token_left_reg - 4'd1;
                if (token_left_reg == 4'd1)
                begin
                    phase_sw = PH_OPT;
                end
            end
            PH_OPT:
            begin
                if (in_byte == PAYLOAD_MARKER)
                begin
                    phase_sw = PH_PAYLOAD;
                end
                else if (opts_seen_reg >= option_limit)
                begin
                    phase_sw = PH_SKIP;
                end
                else if (in_byte[7:4] == NIB_RESERVED || in_byte[3:0] == NIB_RESERVED)
                begin
                    sw_has   = 1'b1;
                    sw_kind  = EV_REJECT;
                    sw_err   = ERR_NIBBLE15;
                    phase_sw = PH_DISCARD;
                end
                else
                begin
                    delta_nib_next  = in_byte[7:4];
                    length_nib_next = in_byte[3:0];
                    len_nib         = in_byte[3:0];
                    if (in_byte[7:4] inside {NIB_EXT1, NIB_EXT2})
                    begin
                        phase_sw = PH_DX1;
                    end
                    else
                    begin
                        delta_val    = {12'd0, in_byte[7:4]};
                        do_len_stage = 1'b1;
                    end
                end
            end
            PH_DX1:
            begin
                if (delta_nib_reg == NIB_EXT1)
                begin
                    delta_val    = EXT1_BASE + {8'd0, in_byte};
                    do_len_stage = 1'b1;
                end
                else
                begin
                    ext_next = in_byte;
                    phase_sw = PH_DX2;
                end
            end
            PH_DX2:
            begin
                delta_val    = EXT2_BASE + {ext_reg, in_byte};
                do_len_stage = 1'b1;
            end
            PH_LX1:
            begin
                if (length_nib_reg == NIB_EXT1)
                begin
                    length_val = EXT1_BASE + {8'd0, in_byte};
                    do_finish  = 1'b1;
                end
                else
                begin
                    ext_next = in_byte;
                    phase_sw = PH_LX2;
                end
            end
            PH_LX2:
            begin
                length_val = EXT2_BASE + {ext_reg, in_byte};
                do_finish  = 1'b1;
            end
            PH_VALUE:
            begin
                sw_has          = 1'b1;
                sw_kind         = EV_OPTBYTE;
                sw_data         = in_byte;
                sw_num          = running_reg;
                sw_len          = opt_length_reg;
                value_left_next = value_left_reg - 16'd1;
                if (value_left_reg == 16'd1)
                begin
                    phase_sw = PH_OPT;
                end
            end
            PH_PAYLOAD:
            begin
                sw_has  = 1'b1;
                sw_kind = EV_PAYLOAD;
                sw_data = in_byte;
            end
            default:
            begin
                // Skipped and discarded bytes change nothing.
            end
        endcase

        // Option delta is settled: go on to the length nibble.
        if (do_len_stage)
        begin
            opt_delta_next = delta_val;
            if (len_nib inside {NIB_EXT1, NIB_EXT2})
            begin
                phase_sw = PH_LX1;
            end
            else
            begin
                length_val = {12'd0, len_nib};
                do_finish  = 1'b1;
            end
        end

        // Option header complete: advance the option number and announce it.
        if (do_finish)
        begin
            run_sum         = running_reg + opt_delta_next;
            running_next    = run_sum;
            opt_length_next = length_val;
            value_left_next = length_val;
            opts_seen_next  = opts_seen_reg + 5'd1;
            sw_has          = 1'b1;
            sw_kind         = EV_OPTSTART;
            sw_num          = run_sum;
            sw_len          = length_val;
            phase_sw        = (length_val != 16'd0) ? PH_VALUE : PH_OPT;
        end

        // The final byte of a datagram ends parsing of this message.
        phase_next = (active && fin) ? PH_DISCARD : phase_sw;
        pos_next   = (active && !fin) ? pos_reg + PW'(1) : pos_reg;
    end

    // Result: the decoded event, with the end-of-datagram checks applied.
    always_comb
    begin
        ev                = '0;
        ev.event_kind     = sw_kind;
        ev.error_code     = sw_err;
        ev.option_number  = sw_num;
        ev.option_length  = sw_len;
        ev.data_out       = sw_data;
        if (fin && !sw_reject)
        begin
            if (phase_sw inside {PH_H1, PH_H2, PH_H3})
            begin
                ev.event_kind    = EV_REJECT;
                ev.error_code    = ERR_SHORT;
                ev.option_number = 16'd0;
                ev.option_length = 16'd0;
                ev.data_out      = 8'd0;
            end
            else if (phase_sw inside {PH_TOKEN, PH_VALUE, PH_DX1, PH_DX2, PH_LX1, PH_LX2})
            begin
                ev.event_kind    = EV_REJECT;
                ev.error_code    = ERR_TRUNCATED;
                ev.option_number = 16'd0;
                ev.option_length = 16'd0;
                ev.data_out      = 8'd0;
            end
            else if (!sw_has)
            begin
                ev.event_kind = EV_END;
            end
        end
        ev.msg_type       = hdr_type_next;
        ev.token_length   = hdr_tkl_next;
        ev.msg_code       = hdr_code_next;
        ev.message_id     = hdr_mid_next;
        ev.end_of_message = fin;
        ev_valid          = in_fire && active && (sw_has || fin);
    end

    // State update; the final byte of a datagram starts a fresh message.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_H0;
            pos_reg        <= '0;
            hold_reg       <= 24'd0;
            token_left_reg <= 4'd0;
            running_reg    <= 16'd0;
            delta_nib_reg  <= 4'd0;
            length_nib_reg <= 4'd0;
            ext_reg        <= 8'd0;
            value_left_reg <= 16'd0;
            opts_seen_reg  <= 5'd0;
            hdr_type_reg   <= 2'd0;
            hdr_tkl_reg    <= 4'd0;
            hdr_code_reg   <= 8'd0;
            hdr_mid_reg    <= 16'd0;
            opt_delta_reg  <= 16'd0;
            opt_length_reg <= 16'd0;
        end
        else if (in_fire && in_last)
        begin
            phase_reg      <= PH_H0;
            pos_reg        <= '0;
            hold_reg       <= 24'd0;
            token_left_reg <= 4'd0;
            running_reg    <= 16'd0;
            delta_nib_reg  <= 4'd0;
            length_nib_reg <= 4'd0;
            ext_reg        <= 8'd0;
            value_left_reg <= 16'd0;
            opts_seen_reg  <= 5'd0;
            hdr_type_reg   <= 2'd0;
            hdr_tkl_reg    <= 4'd0;
            hdr_code_reg   <= 8'd0;
            hdr_mid_reg    <= 16'd0;
            opt_delta_reg  <= 16'd0;
            opt_length_reg <= 16'd0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            hold_reg       <= hold_next;
            token_left_reg <= token_left_next;
            running_reg    <= running_next;
            delta_nib_reg  <= delta_nib_next;
            length_nib_reg <= length_nib_next;
            ext_reg        <= ext_next;
            value_left_reg <= value_left_next;
            opts_seen_reg  <= opts_seen_next;
            hdr_type_reg   <= hdr_type_next;
            hdr_tkl_reg    <= hdr_tkl_next;
            hdr_code_reg   <= hdr_code_next;
            hdr_mid_reg    <= hdr_mid_next;
            opt_delta_reg  <= opt_delta_next;
            opt_length_reg <= opt_length_next;
        end
    end

endmodule

// ----- sv/cmp_out_buf.sv -----
// Result register with a skid stage, so the input ready comes from a flop.
module cmp_out_buf
    import cmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  cmp_event_t in_event,
    output logic       out_valid,
    input  logic       out_ready,
    output cmp_event_t out_event
);

    logic       main_valid_reg;
    logic       skid_valid_reg;
    cmp_event_t main_reg;
    cmp_event_t skid_reg;
    logic       pop;

    assign pop       = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_event = main_reg;

    // Valid flags of the two entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload of the two entries.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (in_valid)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= in_event;
            end
            else
            begin
                main_reg <= in_event;
            end
        end
    end

endmodule

// ----- sv/coap_message_parser.sv -----
// Top level of the CoAP message parser: ports, limit register and result buffer.
//
//   Channel  Direction  Signals                        Moves
//   s_*      in         s_tvalid s_tready s_tdata s_tlast   one datagram byte
//   m_*      out        m_tvalid m_tready m_tdata m_tuser m_tlast  one parser event
//   cfg_*    in         cfg_valid cfg_ready cfg_data    option limit write
//
// One byte is taken per cycle while s_tready is high; the single decode pass of
// cmp_core sets its event, if any; it is registered in the result or skid stage.
// Reset puts the parser at the first header byte with an option limit of 10.
// A stalled output holds one event in the result register and one in the skid
// stage; s_tready drops only while the skid stage is full.
module coap_message_parser
    import cmp_pkg::*;
#(
    parameter int MAX_DATAGRAM = CMP_MAX_DATAGRAM
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [1:0] msg_type, [5:2] token_length, [13:6] msg_code, [29:14] message_id,
    // [45:30] option_number, [61:46] option_length, [69:62] data_out,
    // [72:70] error_code, [79:73] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [TUSER_W-1:0] m_tuser,   // [2:0] event_kind
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data
);

    logic [CFG_W-1:0] option_limit_reg;
    logic             in_fire;
    logic             ev_valid;
    cmp_event_t       ev;
    cmp_event_t       out_ev;

    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Option limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            option_limit_reg <= OPT_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            option_limit_reg <= cfg_data;
        end
    end

    // Byte decode and message state.
    cmp_core #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .option_limit (option_limit_reg),
        .ev_valid     (ev_valid),
        .ev           (ev)
    );

    // Result register and skid stage.
    cmp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ev_valid),
        .in_ready  (s_tready),
        .in_event  (ev),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_event (out_ev)
    );

    // Pack the result fields onto the output transfer.
    assign m_tdata = {{(TDATA_W - FIELDS_W){1'b0}},
                      out_ev.error_code,
                      out_ev.data_out,
                      out_ev.option_length,
                      out_ev.option_number,
                      out_ev.message_id,
                      out_ev.msg_code,
                      out_ev.token_length,
                      out_ev.msg_type};
    assign m_tuser = out_ev.event_kind;
    assign m_tlast = out_ev.end_of_message;

    // Input stalls only while an event is waiting at the output.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with an empty result register");

    // Reject events carry a reason, all others carry none.
    a_error_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_ev.event_kind == EV_REJECT) == (out_ev.error_code != ERR_NONE)))
        else $error("error code does not match event kind");

    // Option fields are zero outside option events.
    a_option_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_ev.event_kind != EV_OPTSTART && out_ev.event_kind != EV_OPTBYTE)
        |-> (out_ev.option_number == 16'd0 && out_ev.option_length == 16'd0))
        else $error("option fields set outside an option event");

    // A stalled output keeps its event until taken.
    a_output_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output event changed");

endmodule
